// ----- hdl/cpl_pkg.sv -----
// Shared constants, types and controller/datapath interface structs for the positional list.
package cpl_pkg;

  // Sizing of the list storage and of the item fields.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned MODE_W   = 3;

  // Operation codes carried by the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_END   = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_END   = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_DUMP      = 3'd6
  } mode_e;

  // Status codes reported with each result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Class of work that a decoded operation needs.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INS  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_DUMP = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    init;
    logic    ins_step;
    logic    del_step;
    logic    ins_put;
    logic    del_put;
    logic    emit_status;
    logic    emit_entry;
    status_e code;
  } cpl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e   kind;
    status_e code;
    logic    at_k;
    logic    at_last;
  } cpl_sts_t;

endpackage

// ----- hdl/cpl_dpath.sv -----
// Datapath of the positional list: entry storage, count, walk index and result registers.
module cpl_dpath import cpl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cpl_cmd_t                 cmd_i,
  output cpl_sts_t                 sts_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] entry_value_o,
  output logic [POS_W-1:0]         entry_position_o,
  output logic [POS_W-1:0]         entry_count_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  logic [MODE_W-1:0]        mode_q;
  logic signed [DATA_W-1:0] value_q;
  logic [POS_W-1:0]         pos_q;
  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         idx_q;
  logic [DATA_W-1:0]        entries_q [CAPACITY];

  logic                     valid_q;
  logic signed [DATA_W-1:0] ev_q;
  logic [POS_W-1:0]         ep_q;
  logic [POS_W-1:0]         ec_q;
  status_e                  st_q;
  logic                     last_q;

  logic [7:0]       cnt8, pos8, idx8;
  logic             is_full, is_empty;
  kind_e            kind;
  status_e          code;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] init_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic             wr_en;
  logic [DATA_W-1:0] wr_data;

  assign cnt8     = 8'(count_q);
  assign pos8     = 8'(pos_q);
  assign idx8     = 8'(idx_q);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Decode the held operation: what it does, where, and whether it fails.
  always_comb begin
    kind = KIND_NONE;
    code = ST_OK;
    k    = '0;
    unique case (mode_q)
      MODE_INS_FRONT: begin
        kind = KIND_INS;
        if (is_full) code = ST_FULL;
      end
      MODE_INS_END: begin
        kind = KIND_INS;
        k    = count_q[IDX_W-1:0];
        if (is_full) code = ST_FULL;
      end
      MODE_INS_POS: begin
        kind = KIND_INS;
        k    = IDX_W'(pos8 - 8'd1);
        if (is_full) code = ST_FULL;
        else if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) code = ST_RANGE;
      end
      MODE_DEL_FRONT: begin
        kind = KIND_DEL;
        if (is_empty) code = ST_EMPTY;
      end
      MODE_DEL_END: begin
        kind = KIND_DEL;
        k    = IDX_W'(cnt8 - 8'd1);
        if (is_empty) code = ST_EMPTY;
      end
      MODE_DEL_POS: begin
        kind = KIND_DEL;
        k    = IDX_W'(pos8 - 8'd1);
        if (is_empty) code = ST_EMPTY;
        else if (pos8 == 8'd0 || pos8 > cnt8) code = ST_RANGE;
      end
      MODE_DUMP: begin
        kind = KIND_DUMP;
        if (is_empty) code = ST_EMPTY;
      end
      default: begin
        kind = KIND_NONE;
      end
    endcase
  end

  assign sts_o.kind    = kind;
  assign sts_o.code    = code;
  assign sts_o.at_k    = (idx_q == k);
  assign sts_o.at_last = (idx8 + 8'd1 == cnt8);

  // Starting index of the walk: inserts shift down from the tail, deletes up from the hole.
  always_comb begin
    case (kind)
      KIND_INS: init_idx = count_q[IDX_W-1:0];
      KIND_DEL: init_idx = k;
      default:  init_idx = '0;
    endcase
  end

  // Single read port; the neighbor of the walk index during shifts.
  always_comb begin
    if (cmd_i.ins_step)      rd_addr = idx_q - IDX_W'(1);
    else if (cmd_i.del_step) rd_addr = idx_q + IDX_W'(1);
    else                     rd_addr = idx_q;
  end
  assign rd_data = entries_q[rd_addr];

  // Single write port at the walk index.
  assign wr_en   = cmd_i.ins_step | cmd_i.del_step | cmd_i.ins_put;
  assign wr_data = cmd_i.ins_put ? DATA_W'(value_q) : rd_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) entries_q[idx_q] <= wr_data;
  end

  // Control registers: entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_status | cmd_i.emit_entry;
      if (cmd_i.ins_put)      count_q <= count_q + CNT_W'(1);
      else if (cmd_i.del_put) count_q <= count_q - CNT_W'(1);
    end
  end

  // Operation operands and the walk index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (cmd_i.init)                            idx_q <= init_idx;
    else if (cmd_i.ins_step)                   idx_q <= idx_q - IDX_W'(1);
    else if (cmd_i.del_step || cmd_i.emit_entry) idx_q <= idx_q + IDX_W'(1);
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      ev_q   <= '0;
      ep_q   <= '0;
      ec_q   <= POS_W'(count_q);
      st_q   <= cmd_i.code;
      last_q <= 1'b1;
    end else if (cmd_i.emit_entry) begin
      ev_q   <= $signed(rd_data);
      ep_q   <= POS_W'(idx8 + 8'd1);
      ec_q   <= POS_W'(count_q);
      st_q   <= ST_OK;
      last_q <= sts_o.at_last;
    end
  end

  assign valid_o          = valid_q;
  assign entry_value_o    = ev_q;
  assign entry_position_o = ep_q;
  assign entry_count_o    = ec_q;
  assign status_o         = st_q;
  assign last_o           = last_q;

  // The count never passes the capacity and moves by at most one per cycle.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY)) else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
    count_q + CNT_W'(1) == $past(count_q)) else $error("entry count jumped");

  // An insert completes only with room left; a delete shift stays inside the list.
  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_put |-> !is_full) else $error("insert committed on a full list");

  a_del_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.del_step |-> (idx8 + 8'd1 < cnt8)) else $error("delete shift beyond the tail");

  // The final beat of an operation is always followed by a quiet cycle.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |=> !valid_q) else $error("result beat right after a final beat");

endmodule

// ----- hdl/cpl_ctrl.sv -----
// Controller state machine of the positional list: sequences decode, shifts and result beats.
module cpl_ctrl import cpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cpl_sts_t sts_i,
  output cpl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_DUMP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and the commands issued in each state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.code != ST_OK || sts_i.kind == KIND_NONE) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.code        = sts_i.code;
          state_d           = S_IDLE;
        end else begin
          cmd_o.init = 1'b1;
          case (sts_i.kind)
            KIND_INS: state_d = S_INS_SHIFT;
            KIND_DEL: state_d = S_DEL_SHIFT;
            default:  state_d = S_DUMP;
          endcase
        end
      end
      S_INS_SHIFT: begin
        if (sts_i.at_k) begin
          cmd_o.ins_put = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.ins_step = 1'b1;
        end
      end
      S_DEL_SHIFT: begin
        if (sts_i.at_last) begin
          cmd_o.del_put = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.del_step = 1'b1;
        end
      end
      S_DUMP: begin
        cmd_o.emit_entry = 1'b1;
        if (sts_i.at_last) state_d = S_IDLE;
      end
      S_FINISH: begin
        cmd_o.emit_status = 1'b1;
        cmd_o.code        = ST_OK;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/circular_positional_list_unit.sv -----
// Top level of the positional list: controller plus datapath.
//
// Bounded ordered list of up to 16 signed 32-bit words, empty after reset. An operation is
// taken when start is high and busy is low. Busy then stays high until the final result beat
// has been issued, so the next operation can be taken at the edge that takes that beat. Every
// result beat appears for exactly one cycle with valid_o high and cannot be held off, so the
// receiver must take it then. Each operation first passes through a decode state. A failed or
// unused operation issues its status beat right after decode. An insert then moves entries
// toward the tail one at a time, writes the new word and issues its status beat. A delete
// moves each entry that follows the hole toward the front, then issues its status beat. A
// dump issues one beat per entry, one per cycle. Shifting is paced by the entry storage,
// which has a single read port and a single write port and moves one word per cycle during
// a shift.
module circular_positional_list_unit import cpl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] entry_value_o,
  output logic [POS_W-1:0]         entry_position_o,
  output logic [POS_W-1:0]         entry_count_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  cpl_cmd_t cmd;
  cpl_sts_t sts;

  // Sequencing.
  cpl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Storage and result registers.
  cpl_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .valid_o          (valid_o),
    .entry_value_o    (entry_value_o),
    .entry_position_o (entry_position_o),
    .entry_count_o    (entry_count_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
